FILE: rtl/ppra_pkg.sv
`default_nettype none
package ppra_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int PAGE_BYTES      = 4096;
    localparam int ADDRESS_BITS    = 48;
    localparam int MAX_RESULTS     = 16;

    localparam int AW  = 48;                 // byte address field width
    localparam int PCW = 37;                 // page count field width
    localparam int PSH = $clog2(PAGE_BYTES);
    localparam int PW  = 38;                 // internal page number width

    localparam int AMB = (ADDRESS_BITS < AW) ? ADDRESS_BITS : AW;
    localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}} >> (AW - AMB);
    // beyond 49 address bits the clamp can no longer bite on a 48 bit sum
    localparam int LIM_SHIFT = ((ADDRESS_BITS < 49) ? ADDRESS_BITS : 49) - PSH;
    localparam logic [PW-1:0] PAGE_LIMIT = PW'(1) << LIM_SHIFT;

    localparam logic [AW-1:0] RESERVE_RESET = AW'(1048576);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_ACQUIRE = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERLAP  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_SHORT    = 3'd4,
        ST_EMPTY    = 3'd5,
        ST_KIND     = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ADD_SCAN,
        S_ALC_COUNT,
        S_ALC_TAKE,
        S_ACQ_SCAN,
        S_LKP_SCAN,
        S_OPEN,
        S_CLOSE,
        S_RESP
    } state_t;

    typedef struct packed {
        op_t             opcode;
        logic [AW-1:0]   address;
        logic [AW-1:0]   byte_count;
        logic [PCW-1:0]  page_count;
        logic            region_kind;
    } item_t;

    typedef struct packed {
        status_t         status;
        logic [AW-1:0]   range_start;
        logic [PCW-1:0]  range_pages;
        logic [5:0]      range_index;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [PW-1:0]   first;
        logic [PW-1:0]   total;
        logic            reserved;
        logic [31:0]     refs;
    } extent_t;

    function automatic logic [PW-1:0] page_up(input logic [AW:0] v);
        page_up = PW'(v >> PSH) + PW'(|v[PSH-1:0]);
    endfunction

    function automatic logic [PW-1:0] page_clamp(input logic [PW-1:0] v);
        page_clamp = (v > PAGE_LIMIT) ? PAGE_LIMIT : v;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [AW-1:0] page_to_byte(input logic [PW-1:0] p);
        logic [PW+PSH-1:0] w;
        w = {p, {PSH{1'b0}}};
        page_to_byte = w[AW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/physical_page_range_allocator_top.sv
// steps: decode in S_IDLE and S_START, then a scan of the table one entry at a time;
//   entries move one at a time when a slot opens or closes; S_RESP (S_ALC_TAKE for
//   allocations) presents the result once the output register is free
// throughput: one request at a time; allocate compacts the table per extent used up
// reset: extent count cleared (table contents are unused until written),
//   reserve_below returns to 1 MiB, no result pending
`default_nettype none
module physical_page_range_allocator_top #(
    parameter int MAX_REGIONS = ppra_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire ppra_pkg::item_t         s_item,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output ppra_pkg::result_t            m_item,
    input  wire logic                    cfg_wr_en,
    input  wire logic [ppra_pkg::AW-1:0] cfg_wr_data
);
    import ppra_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = $clog2(MAX_REGIONS);
    localparam logic [CW-1:0] MAXR = CW'(MAX_REGIONS);

    extent_t extent_reg [MAX_REGIONS];

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [AW-1:0]  reserve_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           close_alc_reg, close_alc_next;
    logic [PW-1:0]  sp_reg, sp_next;
    logic [PW-1:0]  ep_reg, ep_next;
    logic [PW-1:0]  n_reg, n_next;
    logic           kind_reg, kind_next;
    logic           prev_ok_reg, prev_ok_next;
    extent_t        prev_reg, prev_next;
    logic           nxt_ok_reg, nxt_ok_next;
    extent_t        nxt_reg, nxt_next;
    extent_t        ins_reg, ins_next;
    logic [PW-1:0]  got_reg, got_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [PW-1:0]  left_reg, left_next;
    logic [5:0]     r_reg, r_next;
    status_t        rst_reg, rst_next;
    logic [PW-1:0]  rpage_reg, rpage_next;
    logic [PW-1:0]  rpages_reg, rpages_next;
    result_t        out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    logic           wr_en;
    logic [IW-1:0]  wr_idx;
    extent_t        wr_data;
    logic [CW-1:0]  rd_sel;
    extent_t        rd;
    logic           emit;
    result_t        emit_data;
    logic           can_emit;

    // request decode
    logic [AW-1:0]  in_a;
    logic [AW:0]    in_e;
    logic [PW-1:0]  in_pg;
    logic [PW-1:0]  rd_end;
    logic [PW-1:0]  take_n;
    logic           pm, nm;

    assign can_emit = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_item   = out_reg;

    always_comb begin
        unique case (state_reg)
            S_CLOSE: rd_sel = CW'(j_reg + 1'b1);
            S_OPEN:  rd_sel = CW'(j_reg - 1'b1);
            default: rd_sel = i_reg;
        endcase
    end
    assign rd     = extent_reg[rd_sel[IW-1:0]];
    assign rd_end = rd.first + rd.total;

    assign in_a  = s_item.address & ADDR_MASK;
    assign in_e  = {1'b0, in_a} + {1'b0, s_item.byte_count};
    assign in_pg = PW'(in_a >> PSH);

    assign take_n = (rd.total < (n_reg - got_reg)) ? rd.total : (n_reg - got_reg);
    assign pm = prev_ok_reg && (prev_reg.first + prev_reg.total == sp_reg)
                && (prev_reg.reserved == kind_reg);
    assign nm = nxt_ok_reg && (nxt_reg.first == ep_reg) && (nxt_reg.reserved == kind_reg);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        close_alc_next = close_alc_reg;
        sp_next        = sp_reg;
        ep_next        = ep_reg;
        n_next         = n_reg;
        kind_next      = kind_reg;
        prev_ok_next   = prev_ok_reg;
        prev_next      = prev_reg;
        nxt_ok_next    = nxt_ok_reg;
        nxt_next       = nxt_reg;
        ins_next       = ins_reg;
        got_next       = got_reg;
        k_next         = k_reg;
        left_next      = left_reg;
        r_next         = r_reg;
        rst_next       = rst_reg;
        rpage_next     = rpage_reg;
        rpages_next    = rpages_reg;
        wr_en          = 1'b0;
        wr_idx         = i_reg[IW-1:0];
        wr_data        = rd;
        emit           = 1'b0;
        emit_data      = '{status: ST_OK, range_start: '0, range_pages: '0,
                           range_index: '0, last: 1'b1};

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_item.opcode;
                    kind_next = s_item.region_kind;
                    n_next    = PW'(s_item.page_count);
                    if (s_item.opcode == OP_ADD) begin
                        sp_next = page_clamp(page_up({1'b0, in_a}));
                        ep_next = page_clamp(page_up(in_e));
                    end else begin
                        sp_next = in_pg;
                        ep_next = in_pg + PW'(s_item.page_count);
                    end
                    state_next = S_START;
                end
            end
            S_START: begin
                i_next       = '0;
                pos_next     = '0;
                prev_ok_next = 1'b0;
                nxt_ok_next  = 1'b0;
                got_next     = '0;
                k_next       = '0;
                rst_next     = ST_OK;
                rpage_next   = sp_reg;
                rpages_next  = n_reg;
                unique case (op_reg)
                    OP_ADD: begin
                        if (ep_reg <= sp_reg) begin
                            rst_next    = ST_EMPTY;
                            rpages_next = '0;
                            state_next  = S_RESP;
                        end else begin
                            n_next      = ep_reg - sp_reg;
                            rpages_next = ep_reg - sp_reg;
                            if ({ep_reg, {PSH{1'b0}}} < (PW+PSH)'(reserve_reg)) begin
                                kind_next = 1'b1;
                            end
                            state_next = S_ADD_SCAN;
                        end
                    end
                    OP_ALLOC: begin
                        if (n_reg == '0) begin
                            rpage_next = '0;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_ALC_COUNT;
                        end
                    end
                    OP_ACQUIRE: begin
                        state_next = (n_reg == '0) ? S_RESP : S_ACQ_SCAN;
                    end
                    OP_LOOKUP: begin
                        state_next = S_LKP_SCAN;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ADD_SCAN: begin
                if (i_reg < count_reg) begin
                    if (rd.first < ep_reg && sp_reg < rd_end) begin
                        rst_next   = ST_OVERLAP;
                        state_next = S_RESP;
                    end else if (rd.first <= sp_reg) begin
                        prev_ok_next = 1'b1;
                        prev_next    = rd;
                        pos_next     = CW'(i_reg + 1'b1);
                    end else if (!nxt_ok_reg) begin
                        nxt_ok_next = 1'b1;
                        nxt_next    = rd;
                    end
                    i_next = CW'(i_reg + 1'b1);
                end else begin
                    state_next = S_RESP;
                    priority if (pm && nm) begin
                        wr_en          = 1'b1;
                        wr_idx         = IW'(pos_reg - 1'b1);
                        wr_data        = prev_reg;
                        wr_data.total  = prev_reg.total + n_reg + nxt_reg.total;
                        wr_data.refs   = sat_add(prev_reg.refs, nxt_reg.refs);
                        j_next         = pos_reg;
                        close_alc_next = 1'b0;
                        state_next     = S_CLOSE;
                    end else if (pm) begin
                        wr_en         = 1'b1;
                        wr_idx        = IW'(pos_reg - 1'b1);
                        wr_data       = prev_reg;
                        wr_data.total = prev_reg.total + n_reg;
                    end else if (nm) begin
                        wr_en         = 1'b1;
                        wr_idx        = pos_reg[IW-1:0];
                        wr_data       = nxt_reg;
                        wr_data.first = sp_reg;
                        wr_data.total = nxt_reg.total + n_reg;
                    end else if (count_reg >= MAXR) begin
                        rst_next = ST_FULL;
                    end else begin
                        ins_next   = '{first: sp_reg, total: n_reg, reserved: kind_reg,
                                       refs: '0};
                        j_next     = count_reg;
                        state_next = S_OPEN;
                    end
                end
            end
            S_ALC_COUNT: begin
                if (i_reg < count_reg && got_reg < n_reg) begin
                    if (!rd.reserved) begin
                        got_next = got_reg + take_n;
                        k_next   = CW'(k_reg + 1'b1);
                    end
                    i_next = CW'(i_reg + 1'b1);
                end else if (got_reg < n_reg || 32'(k_reg) > 32'(MAX_RESULTS)) begin
                    rst_next    = ST_SHORT;
                    rpage_next  = '0;
                    rpages_next = got_reg;
                    state_next  = S_RESP;
                end else begin
                    left_next  = n_reg;
                    i_next     = '0;
                    r_next     = '0;
                    state_next = S_ALC_TAKE;
                end
            end
            S_ALC_TAKE: begin
                if (left_reg == '0 || i_reg >= count_reg) begin
                    state_next = S_IDLE;
                end else if (rd.reserved) begin
                    i_next = CW'(i_reg + 1'b1);
                end else if (can_emit) begin
                    emit                  = 1'b1;
                    emit_data.range_start = page_to_byte(rd.first);
                    emit_data.range_index = r_reg;
                    r_next                = r_reg + 6'd1;
                    if (rd.total <= left_reg) begin
                        emit_data.range_pages = PCW'(rd.total);
                        emit_data.last        = (rd.total == left_reg);
                        left_next             = left_reg - rd.total;
                        j_next                = i_reg;
                        close_alc_next        = 1'b1;
                        state_next            = S_CLOSE;
                    end else begin
                        emit_data.range_pages = PCW'(left_reg);
                        wr_en                 = 1'b1;
                        wr_data.first         = rd.first + left_reg;
                        wr_data.total         = rd.total - left_reg;
                        left_next             = '0;
                        state_next            = S_IDLE;
                    end
                end
            end
            S_ACQ_SCAN: begin
                if (i_reg >= count_reg) begin
                    rst_next   = ST_NOTFOUND;
                    state_next = S_RESP;
                end else if (rd.first <= sp_reg && ep_reg <= rd_end) begin
                    state_next = S_RESP;
                    if (rd.reserved != kind_reg) begin
                        rst_next = ST_KIND;
                    end else begin
                        priority if (rd.first == sp_reg && rd_end == ep_reg) begin
                            j_next         = i_reg;
                            close_alc_next = 1'b0;
                            state_next     = S_CLOSE;
                        end else if (rd.first == sp_reg) begin
                            wr_en         = 1'b1;
                            wr_data.first = ep_reg;
                            wr_data.total = rd_end - ep_reg;
                        end else if (rd_end == ep_reg) begin
                            wr_en         = 1'b1;
                            wr_data.total = sp_reg - rd.first;
                        end else if (count_reg >= MAXR) begin
                            rst_next = ST_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_data.total = sp_reg - rd.first;
                            ins_next      = '{first: ep_reg, total: rd_end - ep_reg,
                                              reserved: rd.reserved, refs: '0};
                            pos_next      = CW'(i_reg + 1'b1);
                            j_next        = count_reg;
                            state_next    = S_OPEN;
                        end
                    end
                end else begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            S_LKP_SCAN: begin
                if (i_reg >= count_reg) begin
                    rst_next    = ST_NOTFOUND;
                    rpage_next  = '0;
                    rpages_next = '0;
                    state_next  = S_RESP;
                end else if (rd.reserved && rd.first <= sp_reg && sp_reg < rd_end) begin
                    wr_en        = 1'b1;
                    wr_data.refs = sat_add(rd.refs, 32'd1);
                    rpage_next   = rd.first;
                    rpages_next  = rd.total;
                    state_next   = S_RESP;
                end else begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            S_OPEN: begin
                wr_en  = 1'b1;
                wr_idx = j_reg[IW-1:0];
                if (j_reg > pos_reg) begin
                    j_next = CW'(j_reg - 1'b1);
                end else begin
                    wr_data    = ins_reg;
                    count_next = CW'(count_reg + 1'b1);
                    state_next = S_RESP;
                end
            end
            S_CLOSE: begin
                if (CW'(j_reg + 1'b1) < count_reg) begin
                    wr_en  = 1'b1;
                    wr_idx = j_reg[IW-1:0];
                    j_next = CW'(j_reg + 1'b1);
                end else begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = close_alc_reg ? S_ALC_TAKE : S_RESP;
                end
            end
            S_RESP: begin
                if (can_emit) begin
                    emit                  = 1'b1;
                    emit_data.status      = rst_reg;
                    emit_data.range_start = page_to_byte(rpage_reg);
                    emit_data.range_pages = PCW'(rpages_reg);
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (emit) begin
            out_next       = emit_data;
            out_valid_next = 1'b1;
        end else begin
            out_next       = out_reg;
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            reserve_reg   <= RESERVE_RESET;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                reserve_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        pos_reg       <= pos_next;
        close_alc_reg <= close_alc_next;
        sp_reg        <= sp_next;
        ep_reg        <= ep_next;
        n_reg         <= n_next;
        kind_reg      <= kind_next;
        prev_ok_reg   <= prev_ok_next;
        prev_reg      <= prev_next;
        nxt_ok_reg    <= nxt_ok_next;
        nxt_reg       <= nxt_next;
        ins_reg       <= ins_next;
        got_reg       <= got_next;
        k_reg         <= k_next;
        left_reg      <= left_next;
        r_reg         <= r_next;
        rst_reg       <= rst_next;
        rpage_reg     <= rpage_next;
        rpages_reg    <= rpages_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            extent_reg[wr_idx] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAXR)
        else $error("extent count beyond table depth");

    a_open_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OPEN |-> count_reg < MAXR)
        else $error("slot opened in a full table");

    a_alloc_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALC_TAKE && emit) |-> emit_data.range_pages != '0)
        else $error("allocation transfer with no pages");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transfer");

endmodule
`default_nettype wire
